/* rtl/tc_pkg.sv */
`default_nettype none
package tc_pkg;

    // angle and result widths
    localparam int ANGLE_W   = 16;
    localparam int COS_W     = 16;
    // pi in Q3.13
    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 16'sd25736;

    // Horner accumulator: signed Q.30, headroom for |p| up to cosh(pi)
    localparam int P_W       = 36;
    // x squared, Q6.26, always below 2^30
    localparam int S_W       = 30;
    // s is split in two halves for the partial products
    localparam int SH_W      = 15;
    // partial product: P_W x (SH_W + sign bit)
    localparam int PP_W      = P_W + SH_W + 1;
    // recombined product
    localparam int SUM_W     = PP_W + SH_W;
    // Q.56 -> Q.30 and Q.30 -> Q2.14 shifts
    localparam int PROD_SH   = 26;
    localparam int OUT_SH    = 16;
    localparam int R_W       = P_W - OUT_SH;

    localparam int MAX_TERMS = 6;

    // 1/(2k)! in Q.30, rounded to nearest
    localparam logic signed [P_W-1:0] INV_FACT [MAX_TERMS] = '{
        36'sd1073741824,
        36'sd536870912,
        36'sd44739243,
        36'sd1491308,
        36'sd26631,
        36'sd296
    };

    // one request as it travels down the Horner chain
    typedef struct packed {
        logic signed [P_W-1:0] p;
        logic [S_W-1:0]        s;
    } t_horner;

endpackage
`default_nettype wire

/* rtl/taylor_cosine_top.sv */
// Cosine by a truncated Maclaurin series, fully pipelined.
// Slave stream (i_s_*): one angle per request, signed Q3.13 radians in
// i_s_tdata; angles beyond plus or minus pi are clamped to the bound.
// Master stream (o_m_*): one cosine per request, signed Q2.14, rounded
// to nearest, in the same order as the angles went in.
// Path: a request passes the clamp and square registers, then for each Horner step
// the split multiply register and the recombine, round and subtract register,
// and last the final rounding register that drives o_m_tvalid.
// Throughput: one angle per cycle while the output is not stalled; every stage
// holds a valid bit and moves when the stage after it is empty or moving.
// Stall: while i_m_tready is low the result is held; upstream stages keep
// filling any empty slots, and o_s_tready drops only once the whole
// pipeline is full. Nothing is dropped or repeated.
// Reset (i_rst_n low, synchronous): all valid bits clear, the pipeline is
// empty and o_s_tready is high from the next cycle.
`default_nettype none
module taylor_cosine_top #(
    parameter int TERMS = 6
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // [15:0] angle
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata    // [15:0] cosine
);
    import tc_pkg::*;

    // term count held to the coefficient table
    localparam int NT     = (TERMS < 1) ? 1 : ((TERMS > MAX_TERMS) ? MAX_TERMS : TERMS);
    localparam int N_STEP = NT - 1;

    t_horner          w_h [N_STEP+1];
    logic             w_v [N_STEP+1];
    logic             w_r [N_STEP+1];
    logic [S_W-1:0]   w_s0;
    logic signed [COS_W-1:0] w_cos;

    // clamp and square
    tc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_angle ($signed(i_s_tdata)),
        .o_valid (w_v[0]),
        .i_ready (w_r[0]),
        .o_s     (w_s0)
    );

    // Horner seed is the highest coefficient
    assign w_h[0] = '{p: INV_FACT[NT-1], s: w_s0};

    // one step per remaining coefficient, highest first
    for (genvar j = 0; j < N_STEP; j++) begin : g_step
        tc_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[j]),
            .o_ready (w_r[j]),
            .i_data  (w_h[j]),
            .i_coef  (INV_FACT[NT-2-j]),
            .o_valid (w_v[j+1]),
            .i_ready (w_r[j+1]),
            .o_data  (w_h[j+1])
        );
    end

    // final rounding and output register
    tc_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v[N_STEP]),
        .o_ready (w_r[N_STEP]),
        .i_p     (w_h[N_STEP].p),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_cos   (w_cos)
    );

    assign o_m_tdata = w_cos;

endmodule
`default_nettype wire

/* rtl/tc_front.sv */
`default_nettype none
module tc_front (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic signed [tc_pkg::ANGLE_W-1:0]  i_angle,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic [tc_pkg::S_W-1:0]                  o_s
);
    import tc_pkg::*;

    logic                        r_valid_x;
    logic signed [ANGLE_W-1:0]   r_x;
    logic                        r_valid_s;
    logic [S_W-1:0]              r_s;

    logic                        w_ready_x;
    logic                        w_ready_s;
    logic signed [ANGLE_W-1:0]   n_x;
    logic signed [2*ANGLE_W-1:0] w_sq;

    // per-stage flow control
    assign w_ready_s = !r_valid_s || i_ready;
    assign w_ready_x = !r_valid_x || w_ready_s;
    assign o_ready   = w_ready_x;

    // clamp to plus or minus pi
    always_comb begin
        if (i_angle > ANGLE_MAX) begin
            n_x = ANGLE_MAX;
        end else if (i_angle < -ANGLE_MAX) begin
            n_x = -ANGLE_MAX;
        end else begin
            n_x = i_angle;
        end
    end

    assign w_sq = r_x * r_x;

    // stage 1: saturated angle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_x <= 1'b0;
        end else if (w_ready_x) begin
            r_valid_x <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_x && i_valid) begin
            r_x <= n_x;
        end
    end

    // stage 2: square, non-negative and below 2^30
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_s <= 1'b0;
        end else if (w_ready_s) begin
            r_valid_s <= r_valid_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_s && r_valid_x) begin
            r_s <= w_sq[S_W-1:0];
        end
    end

    assign o_valid = r_valid_s;
    assign o_s     = r_s;

endmodule
`default_nettype wire

/* rtl/tc_step.sv */
`default_nettype none
module tc_step (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire tc_pkg::t_horner                i_data,
    input  wire logic signed [tc_pkg::P_W-1:0]  i_coef,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output tc_pkg::t_horner                     o_data
);
    import tc_pkg::*;

    logic                     r_valid_a;
    logic signed [PP_W-1:0]   r_pp_lo;
    logic signed [PP_W-1:0]   r_pp_hi;
    logic [S_W-1:0]           r_s_a;
    logic                     r_valid_b;
    t_horner                  r_out;

    logic                     w_ready_a;
    logic                     w_ready_b;
    logic signed [PP_W-1:0]   n_pp_lo;
    logic signed [PP_W-1:0]   n_pp_hi;
    logic signed [SUM_W-1:0]  w_sum;
    logic signed [SUM_W-1:0]  w_shift;
    logic signed [P_W-1:0]    n_p;

    // per-stage flow control
    assign w_ready_b = !r_valid_b || i_ready;
    assign w_ready_a = !r_valid_a || w_ready_b;
    assign o_ready   = w_ready_a;

    // stage A: p times each half of s
    assign n_pp_lo = i_data.p * $signed({1'b0, i_data.s[SH_W-1:0]});
    assign n_pp_hi = i_data.p * $signed({1'b0, i_data.s[S_W-1:SH_W]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
        end else if (w_ready_a) begin
            r_valid_a <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_a && i_valid) begin
            r_pp_lo <= n_pp_lo;
            r_pp_hi <= n_pp_hi;
            r_s_a   <= i_data.s;
        end
    end

    // stage B: recombine, round to Q.30 (ties up), subtract from coefficient
    assign w_sum   = (SUM_W'(r_pp_hi) <<< SH_W) + SUM_W'(r_pp_lo)
                   + (SUM_W'(1) <<< (PROD_SH - 1));
    assign w_shift = w_sum >>> PROD_SH;
    assign n_p     = i_coef - w_shift[P_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_b <= 1'b0;
        end else if (w_ready_b) begin
            r_valid_b <= r_valid_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_b && r_valid_a) begin
            r_out.p <= n_p;
            r_out.s <= r_s_a;
        end
    end

    assign o_valid = r_valid_b;
    assign o_data  = r_out;

endmodule
`default_nettype wire

/* rtl/tc_round.sv */
`default_nettype none
module tc_round (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic signed [tc_pkg::P_W-1:0]  i_p,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic signed [tc_pkg::COS_W-1:0]     o_cos
);
    import tc_pkg::*;

    localparam logic signed [R_W-1:0] R_MAX = R_W'(32767);
    localparam logic signed [R_W-1:0] R_MIN = -R_W'(32768);

    logic                       r_valid;
    logic signed [COS_W-1:0]    r_cos;

    logic                       w_ready;
    logic signed [P_W-1:0]      w_biased;
    logic signed [P_W-1:0]      w_shift;
    logic signed [R_W-1:0]      w_r;
    logic signed [COS_W-1:0]    n_cos;

    // output register, free when empty or taken
    assign w_ready = !r_valid || i_ready;
    assign o_ready = w_ready;

    // Q.30 -> Q2.14, nearest with ties up, then clamp
    assign w_biased = i_p + (P_W'(1) <<< (OUT_SH - 1));
    assign w_shift  = w_biased >>> OUT_SH;
    assign w_r      = w_shift[R_W-1:0];

    always_comb begin
        if (w_r > R_MAX) begin
            n_cos = R_MAX[COS_W-1:0];
        end else if (w_r < R_MIN) begin
            n_cos = R_MIN[COS_W-1:0];
        end else begin
            n_cos = w_r[COS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_valid) begin
            r_cos <= n_cos;
        end
    end

    assign o_valid = r_valid;
    assign o_cos   = r_cos;

endmodule
`default_nettype wire
